// File: hw/rtl/ism_pkg.sv
package ism_pkg;

  localparam int OpW        = 32;
  localparam int RadW       = 32;
  localparam int RootOutW   = 16;
  localparam int ProdW      = 2 * OpW;
  localparam int RootW      = (RadW + 1) / 2;
  localparam int PadW       = 2 * RootW;
  localparam int RemW       = RootW + 2;
  localparam int BitsPerStg = 2;
  localparam int RootStages = (RootW + BitsPerStg - 1) / BitsPerStg;
  localparam int CmpW       = (RootW > RootOutW) ? RootW : RootOutW;
  localparam int FrontDepth = 3;
  localparam int Depth      = FrontDepth + RootStages + 1;
  localparam int CntW       = $clog2(Depth + 1);

  localparam logic [RootOutW-1:0] RootMax = 16'hFFFF;

  typedef enum logic {
    CmdRoot = 1'b0,
    CmdMag  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            valid;
    logic [RadW-1:0] radicand;
  } rad_beat_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [PadW-1:0]  rad;
  } root_work_t;

  // one restoring digit step: pull two radicand bits, try root*4+1
  function automatic root_work_t root_step(input root_work_t w);
    logic [RemW-1:0] sh;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] diff;
    root_work_t      n;
    sh    = {w.rem[RootW-1:0], w.rad[PadW-1 -: 2]};
    trial = {w.root, 2'b01};
    diff  = sh - trial;
    n.rad = {w.rad[PadW-3:0], 2'b00};
    if (sh >= trial) begin
      n.rem  = diff;
      n.root = {w.root[RootW-2:0], 1'b1};
    end else begin
      n.rem  = sh;
      n.root = {w.root[RootW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/ism_if.sv
interface ism_in_if import ism_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic signed [OpW-1:0] operand_a;
  logic signed [OpW-1:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface ism_out_if import ism_pkg::*;;
  logic                valid;
  logic                ready;
  logic [RootOutW-1:0] root;

  modport source (output valid, root, input ready);
  modport sink   (input valid, root, output ready);
endinterface

// File: hw/rtl/ism_square.sv
module ism_square import ism_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ism_in_if.sink    in_i,
  output rad_beat_t beat_o,
  input  logic      ready_i
);

  logic             v1_q, v2_q, v3_q;
  logic             en1, en2, en3;
  logic             cmd1_q, cmd2_q;
  logic [OpW-1:0]   ma1_d, mb1_d, plain1_d;
  logic [OpW-1:0]   ma1_q, mb1_q, plain1_q, plain2_q;
  logic [ProdW-1:0] sqa2_d, sqb2_d;
  logic [ProdW-1:0] sqa2_q, sqb2_q;
  logic [ProdW-1:0] sum3;
  logic [RadW-1:0]  rad3_d, rad3_q;

  assign en3       = !v3_q || ready_i;
  assign en2       = !v2_q || en3;
  assign en1       = !v1_q || en2;
  assign in_i.ready = en1;

  // stage 1: absolute values, plain root radicand
  always_comb begin
    ma1_d    = in_i.operand_a[OpW-1] ? (~in_i.operand_a + 1'b1) : in_i.operand_a;
    mb1_d    = in_i.operand_b[OpW-1] ? (~in_i.operand_b + 1'b1) : in_i.operand_b;
    plain1_d = in_i.operand_a[OpW-1] ? '0 : in_i.operand_a;
  end

  // stage 2: squares
  always_comb begin
    sqa2_d = ProdW'(ma1_q) * ProdW'(ma1_q);
    sqb2_d = ProdW'(mb1_q) * ProdW'(mb1_q);
  end

  // stage 3: sum, wrap to radicand width, select
  always_comb begin
    sum3   = sqa2_q + sqb2_q;
    rad3_d = (cmd2_q == CmdMag) ? RadW'(sum3) : RadW'(ProdW'(plain2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      cmd1_q   <= in_i.command;
      ma1_q    <= ma1_d;
      mb1_q    <= mb1_d;
      plain1_q <= plain1_d;
    end
    if (en2 && v1_q) begin
      cmd2_q   <= cmd1_q;
      sqa2_q   <= sqa2_d;
      sqb2_q   <= sqb2_d;
      plain2_q <= plain1_q;
    end
    if (en3 && v2_q) begin
      rad3_q <= rad3_d;
    end
  end

  assign beat_o = '{valid: v3_q, radicand: rad3_q};

endmodule

// File: hw/rtl/ism_root.sv
module ism_root import ism_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rad_beat_t  beat_i,
  output logic       ready_o,
  ism_out_if.source  out_o
);

  logic [RootStages-1:0] vld;
  logic [RootStages:0]   en;
  root_work_t            w_q [RootStages];
  logic [RootW-1:0]      fin_root;
  logic [RootOutW-1:0]   sat_d, root_q;
  logic                  out_v_q;

  assign en[RootStages] = !out_v_q || out_o.ready;
  assign ready_o        = en[0];

  for (genvar k = 0; k < RootStages; k++) begin : g_stage
    root_work_t src;
    root_work_t acc;
    logic       src_v;
    logic       v_q;

    if (k == 0) begin : g_first
      assign src_v = beat_i.valid;
      assign src   = '{rem: '0, root: '0, rad: PadW'(beat_i.radicand)};
    end else begin : g_next
      assign src_v = vld[k-1];
      assign src   = w_q[k-1];
    end

    always_comb begin
      acc = src;
      for (int j = 0; j < BitsPerStg; j++) begin
        if (k * BitsPerStg + j < RootW) begin
          acc = root_step(acc);
        end
      end
    end

    assign en[k]  = !v_q || en[k+1];
    assign vld[k] = v_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en[k]) begin
        v_q <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && src_v) begin
        w_q[k] <= acc;
      end
    end
  end

  // clamp to the output width
  always_comb begin
    fin_root = w_q[RootStages-1].root;
    sat_d    = (CmpW'(fin_root) > CmpW'(RootMax)) ? RootMax : RootOutW'(fin_root);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en[RootStages]) begin
      out_v_q <= vld[RootStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[RootStages] && vld[RootStages-1]) begin
      root_q <= sat_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.root  = root_q;

endmodule

// File: hw/rtl/integer_sqrt_and_magnitude_unit.sv
// pipeline: 3 square stages, 8 root stages, 1 output register between item accept and result
//   valid; a result waits in the output register while the output is stalled
// throughput: one item per cycle unless stalled; each root stage resolves two result bits
// stalls hold each stage in place, bubbles collapse so items keep entering
// reset: asynchronous, active low; clears all valid bits, the pipeline comes up empty
module integer_sqrt_and_magnitude_unit import ism_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ism_in_if.sink    in_i,
  ism_out_if.source out_o
);

  rad_beat_t beat;
  logic      root_ready;

  ism_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .beat_o  (beat),
    .ready_i (root_ready)
  );

  ism_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .ready_o (root_ready),
    .out_o   (out_o)
  );

endmodule

// File: hw/rtl/ism_checker.sv
module ism_checker import ism_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [RootOutW-1:0] root_i
);

  logic [CntW-1:0] cnt_q, cnt_d;

  // items inside the block
  assign cnt_d = cnt_q + CntW'(in_valid_i && in_ready_i) - CntW'(out_valid_i && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(root_i))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result without a pending item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("more items in flight than pipeline stages");

  a_refuse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> cnt_q != '0)
    else $error("input refused while empty");

endmodule

bind integer_sqrt_and_magnitude_unit ism_checker u_ism_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .root_i      (out_o.root)
);

// File: bench/tb_integer_sqrt_and_magnitude_unit.sv
`timescale 1ns / 100ps

module tb_integer_sqrt_and_magnitude_unit;
  import ism_pkg::*;

  localparam int RandomItems = 1630;
  localparam int StallLimit  = 2000;

  class root_scoreboard;
    logic [RootOutW-1:0] expected_roots[$];
    int                  n_errors;

    function new();
      n_errors = 0;
    endfunction

    function logic [RootOutW-1:0] floor_root_of(cmd_e cmd, logic signed [OpW-1:0] a,
                                               logic signed [OpW-1:0] b);
      logic [63:0]     abs_a;
      logic [63:0]     abs_b;
      logic [63:0]     sum_sq;
      logic [63:0]     sq;
      logic [RadW-1:0] rad;
      logic [31:0]     root;
      logic [31:0]     trial;
      abs_a = a[OpW-1] ? (64'd1 << 32) - {32'd0, a} : {32'd0, a};
      abs_b = b[OpW-1] ? (64'd1 << 32) - {32'd0, b} : {32'd0, b};
      if (cmd == CmdRoot) begin
        sum_sq = a[OpW-1] ? 64'd0 : {32'd0, a};
      end else begin
        sum_sq = abs_a * abs_a + abs_b * abs_b;
      end
      rad  = sum_sq[RadW-1:0];
      root = '0;
      for (int i = 31; i >= 0; i--) begin
        trial = root | (32'd1 << i);
        sq    = {32'd0, trial} * {32'd0, trial};
        if (sq <= 64'(rad)) begin
          root = trial;
        end
      end
      if (root > 32'(RootMax)) begin
        return RootMax;
      end
      return root[RootOutW-1:0];
    endfunction

    function void note_item(cmd_e cmd, logic signed [OpW-1:0] a, logic signed [OpW-1:0] b);
      expected_roots.push_back(floor_root_of(cmd, a, b));
    endfunction

    function void check_root(logic [RootOutW-1:0] got);
      logic [RootOutW-1:0] want;
      if (expected_roots.size() == 0) begin
        if (n_errors < 10) begin
          $display("unexpected result: root %0d", got);
        end
        n_errors++;
        return;
      end
      want = expected_roots.pop_front();
      if (got !== want) begin
        if (n_errors < 10) begin
          $display("root mismatch: expected %0d, got %0d", want, got);
        end
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   tx_gappy;
  bit   rx_gappy;
  int   idle_cycles;

  root_scoreboard roots;

  ism_in_if  in_if ();
  ism_out_if out_if ();

  integer_sqrt_and_magnitude_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_item(input cmd_e cmd, input logic signed [OpW-1:0] a,
                           input logic signed [OpW-1:0] b);
    int gap;
    gap = tx_gappy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk_i); while (!in_if.ready);
    roots.note_item(cmd, a, b);
  endtask

  task automatic take_results();
    int stall;
    int n_taken;
    n_taken = 0;
    forever begin
      if (n_taken % 64 == 0) begin
        rx_gappy = ($urandom_range(0, 2) != 0);
      end
      stall = rx_gappy ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      roots.check_root(out_if.root);
      n_taken++;
    end
  endtask

  function automatic logic signed [OpW-1:0] pick_operand();
    logic signed [OpW-1:0] v;
    int unsigned           r;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 300);
      2: v = $urandom_range(0, 65536);
      3: begin
        case ($urandom_range(0, 7))
          0: v = 32'sh0000_0000;
          1: v = 32'sh0000_0001;
          2: v = -32'sd1;
          3: v = 32'sh7FFF_FFFF;
          4: v = 32'sh8000_0000;
          5: v = 32'sd65535;
          6: v = 32'sd65536;
          default: v = 32'sd46341;
        endcase
      end
      default: begin
        r = $urandom_range(0, 46340);
        v = r * r + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1) && v != 32'sh8000_0000) begin
      v = -v;
    end
    return v;
  endfunction

  initial begin
    roots            = new();
    idle_cycles      = 0;
    tx_gappy         = 1'b1;
    rx_gappy         = 1'b1;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.command    = CmdRoot;
    in_if.operand_a  = '0;
    in_if.operand_b  = '0;
    out_if.ready     = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    fork
      take_results();
    join_none

    // plain roots: zero, small, perfect squares, top of range, negatives
    send_item(CmdRoot, 32'sd0, 32'sd0);
    send_item(CmdRoot, 32'sd1, -32'sd1);
    send_item(CmdRoot, 32'sd3, 32'sd0);
    send_item(CmdRoot, 32'sd4, 32'sh7FFF_FFFF);
    send_item(CmdRoot, 32'sd2147395600, 32'sd0);
    send_item(CmdRoot, 32'sd2147395599, 32'sd0);
    send_item(CmdRoot, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(CmdRoot, 32'sh8000_0000, 32'sd5);
    send_item(CmdRoot, -32'sd1, 32'sd0);
    send_item(CmdRoot, -32'sd4, 32'sd9);
    // magnitudes, including the top of the root range and wraparound of the sum
    send_item(CmdMag, 32'sd0, 32'sd0);
    send_item(CmdMag, 32'sd3, -32'sd4);
    send_item(CmdMag, -32'sd5, 32'sd12);
    send_item(CmdMag, 32'sd65535, 32'sd0);
    send_item(CmdMag, -32'sd65535, 32'sd1);
    send_item(CmdMag, 32'sd65535, 32'sd361);
    send_item(CmdMag, 32'sd65536, 32'sd0);
    send_item(CmdMag, 32'sd65536, -32'sd3);
    send_item(CmdMag, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CmdMag, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(CmdMag, -32'sd1, -32'sd1);
    send_item(CmdMag, 32'sd46341, 32'sd46341);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) begin
        tx_gappy = ($urandom_range(0, 2) != 0);
      end
      send_item($urandom_range(0, 1) ? CmdMag : CmdRoot, pick_operand(), pick_operand());
      if (n == RandomItems / 2) begin
        // hold off until the pipeline has drained
        in_if.valid <= 1'b0;
        while (roots.pending() != 0) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;

    while (roots.pending() != 0) @(posedge clk_i);
    repeat (2 * Depth) @(posedge clk_i);

    if (roots.n_errors == 0 && roots.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
